// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CHK_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication after a fixed number of cycles, disabled while reset is low
`define CHK_DELAY(lbl, clk, rstn, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##dly (cons)) \
        else $error("assertion failed");

`endif

// ----- design/sbri_pkg.sv -----
// ---------------------------------------------------------------------------
// sbri_pkg
// Shared constants and types for the ray versus box slab test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbri_pkg;

    localparam int FRAC_W   = 16;              // Q16.16 fraction bits
    localparam int QBITS    = 31;              // quotient magnitude bits
    localparam int NUM_W    = 35;              // edge distance width, signed
    localparam int HI_SH    = QBITS - FRAC_W;  // shift that gives the first partial remainder
    localparam int DIV_LAT  = QBITS + 3;       // divider register stages
    localparam int PIPE_LAT = DIV_LAT + 8;     // request to result strobe

    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;

    // Per-request data that travels beside the dividers
    typedef struct packed {
        logic               mode;
        logic               miss;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } t_sb;

endpackage

// ----- design/sbri_div.sv -----
// ---------------------------------------------------------------------------
// sbri_div
// Pipelined signed divider: (num * 2^16) / den, truncated toward zero and
// saturated to +-T_MAX. One quotient bit per stage, a new request every cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbri_div (
    input  logic                              i_clk,
    input  logic signed [sbri_pkg::NUM_W-1:0] i_num,
    input  logic signed [31:0]                i_den,
    output logic signed [31:0]                o_quo,
    output logic                              o_ok
);
    import sbri_pkg::*;

    localparam int HI_W = NUM_W - HI_SH;

    // operand magnitudes
    logic [NUM_W-1:0] r_an;
    logic [31:0]      r_ad;
    logic             r_neg;
    logic             r_dz;
    logic             r_nz;

    // bit-serial stages
    logic [31:0]      r_rem [0:QBITS];
    logic [QBITS-1:0] r_low [0:QBITS];
    logic [QBITS-1:0] r_q   [0:QBITS];
    logic [31:0]      r_d   [0:QBITS];
    logic             r_sn  [0:QBITS];
    logic             r_ovf [0:QBITS];
    logic             r_ok  [0:QBITS];

    logic [HI_W-1:0]  n_hi;
    logic [31:0]      n_mag;

    // take magnitudes and signs
    always_ff @(posedge i_clk) begin
        r_an  <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        r_ad  <= i_den[31] ? 32'(-i_den) : 32'(i_den);
        r_neg <= i_num[NUM_W-1] ^ i_den[31];
        r_dz  <= (i_den == '0);
        r_nz  <= (i_num == '0);
    end

    // quotient of 2^31 or more saturates; otherwise the top part is the first remainder
    assign n_hi = r_an[NUM_W-1:HI_SH];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= 32'(n_hi);
        r_low[0] <= {r_an[HI_SH-1:0], {FRAC_W{1'b0}}};
        r_q[0]   <= '0;
        r_d[0]   <= r_ad;
        r_sn[0]  <= r_neg;
        r_ovf[0] <= r_dz | (32'(n_hi) >= r_ad);
        r_ok[0]  <= ~(r_dz & r_nz);
    end

    // one restoring step per stage
    for (genvar k = 0; k < QBITS; k++) begin : g_step
        logic [32:0] t;
        logic        ge;
        assign t  = {r_rem[k], r_low[k][QBITS-1]};
        assign ge = (t >= {1'b0, r_d[k]});
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? 32'(t - {1'b0, r_d[k]}) : t[31:0];
            r_low[k+1] <= r_low[k] << 1;
            r_q[k+1]   <= {r_q[k][QBITS-2:0], ge};
            r_d[k+1]   <= r_d[k];
            r_sn[k+1]  <= r_sn[k];
            r_ovf[k+1] <= r_ovf[k];
            r_ok[k+1]  <= r_ok[k];
        end
    end

    // saturate and restore sign
    assign n_mag = r_ovf[QBITS] ? T_MAX : {1'b0, r_q[QBITS]};

    always_ff @(posedge i_clk) begin
        o_quo <= r_sn[QBITS] ? -$signed(n_mag) : $signed(n_mag);
        o_ok  <= r_ok[QBITS];
    end

endmodule

// ----- design/swept_box_ray_intersect.sv -----
// Throughput: one request per cycle; busy stays low, results cannot be held off.
// The four slab dividers are 34-stage bit-serial pipelines and set the depth.
// Reset (i_rst_n low, synchronous) clears all valid bits; requests in flight are dropped.
// ---------------------------------------------------------------------------
// swept_box_ray_intersect
// 2D ray or swept box versus axis-aligned box slab test, signed Q16.16.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swept_box_ray_intersect (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_box_left,
    input  logic signed [31:0] i_box_top,
    input  logic [30:0]        i_box_width,
    input  logic [30:0]        i_box_height,
    input  logic [30:0]        i_mover_width,
    input  logic [30:0]        i_mover_height,
    output logic               o_valid,
    output logic               o_hit,
    output logic signed [31:0] o_entry_time,
    output logic signed [31:0] o_contact_x,
    output logic signed [31:0] o_contact_y,
    output logic signed [1:0]  o_normal_x,
    output logic signed [1:0]  o_normal_y
);
    import sbri_pkg::*;

    assign busy = 1'b0;

    // ---- stage 0: capture request
    logic               r0_v;
    t_sb                r0_sb;
    logic signed [31:0] r0_lx, r0_ly;
    logic [30:0]        r0_wx, r0_wy, r0_mw, r0_mh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_sb.mode <= i_mode;
        r0_sb.miss <= 1'b0;
        r0_sb.ox   <= i_origin_x;
        r0_sb.oy   <= i_origin_y;
        r0_sb.dx   <= i_dir_x;
        r0_sb.dy   <= i_dir_y;
        r0_lx      <= i_box_left;
        r0_ly      <= i_box_top;
        r0_wx      <= i_box_width;
        r0_wy      <= i_box_height;
        r0_mw      <= i_mover_width;
        r0_mh      <= i_mover_height;
    end

    // ---- stage 1: grow box in swept mode
    logic               r1_v;
    t_sb                r1_sb;
    t_sb                n1_sb;
    logic signed [33:0] r1_lx, r1_ly;
    logic [32:0]        r1_wx, r1_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
    end

    // zero velocity in swept mode is a miss
    always_comb begin
        n1_sb      = r0_sb;
        n1_sb.miss = r0_sb.mode & (r0_sb.dx == '0) & (r0_sb.dy == '0);
    end

    always_ff @(posedge i_clk) begin
        r1_sb <= n1_sb;
        r1_lx <= 34'(r0_lx) - (r0_sb.mode ? $signed({4'b0, r0_mw[30:1]}) : 34'sd0);
        r1_ly <= 34'(r0_ly) - (r0_sb.mode ? $signed({4'b0, r0_mh[30:1]}) : 34'sd0);
        r1_wx <= {2'b0, r0_wx} + (r0_sb.mode ? {2'b0, r0_mw} : 33'd0);
        r1_wy <= {2'b0, r0_wy} + (r0_sb.mode ? {2'b0, r0_mh} : 33'd0);
    end

    // ---- stage 2: far edges, near distances
    logic                    r2_v;
    t_sb                     r2_sb;
    logic signed [NUM_W-1:0] r2_fex, r2_fey, r2_nnx, r2_nny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_sb  <= r1_sb;
        r2_fex <= NUM_W'(r1_lx) + $signed(NUM_W'(r1_wx));
        r2_fey <= NUM_W'(r1_ly) + $signed(NUM_W'(r1_wy));
        r2_nnx <= NUM_W'(r1_lx) - NUM_W'(r1_sb.ox);
        r2_nny <= NUM_W'(r1_ly) - NUM_W'(r1_sb.oy);
    end

    // ---- stage 3: far distances
    logic                    r3_v;
    t_sb                     r3_sb;
    logic signed [NUM_W-1:0] r3_fnx, r3_fny, r3_nnx, r3_nny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_sb  <= r2_sb;
        r3_fnx <= r2_fex - NUM_W'(r2_sb.ox);
        r3_fny <= r2_fey - NUM_W'(r2_sb.oy);
        r3_nnx <= r2_nnx;
        r3_nny <= r2_nny;
    end

    // ---- slab dividers
    logic signed [31:0] q_fx, q_fy, q_nx, q_ny;
    logic               ok_fx, ok_fy, ok_nx, ok_ny;

    sbri_div u_div_fx (.i_clk, .i_num(r3_fnx), .i_den(r3_sb.dx), .o_quo(q_fx), .o_ok(ok_fx));
    sbri_div u_div_fy (.i_clk, .i_num(r3_fny), .i_den(r3_sb.dy), .o_quo(q_fy), .o_ok(ok_fy));
    sbri_div u_div_nx (.i_clk, .i_num(r3_nnx), .i_den(r3_sb.dx), .o_quo(q_nx), .o_ok(ok_nx));
    sbri_div u_div_ny (.i_clk, .i_num(r3_nny), .i_den(r3_sb.dy), .o_quo(q_ny), .o_ok(ok_ny));

    // delay line matching the dividers
    logic r_dv [0:DIV_LAT-1];
    t_sb  r_dl [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r3_v;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl[0] <= r3_sb;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_dl[k] <= r_dl[k-1];
        end
    end

    // ---- stage C1: order near/far per axis
    logic               rc1_v;
    t_sb                rc1_sb;
    t_sb                nc1_sb;
    logic signed [31:0] rc1_nx, rc1_fx, rc1_ny, rc1_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc1_v <= 1'b0;
        end else begin
            rc1_v <= r_dv[DIV_LAT-1];
        end
    end

    // any zero over zero slab is a miss
    always_comb begin
        nc1_sb      = r_dl[DIV_LAT-1];
        nc1_sb.miss = r_dl[DIV_LAT-1].miss | ~(ok_fx & ok_fy & ok_nx & ok_ny);
    end

    always_ff @(posedge i_clk) begin
        rc1_sb <= nc1_sb;
        rc1_nx <= (q_nx > q_fx) ? q_fx : q_nx;
        rc1_fx <= (q_nx > q_fx) ? q_nx : q_fx;
        rc1_ny <= (q_ny > q_fy) ? q_fy : q_ny;
        rc1_fy <= (q_ny > q_fy) ? q_ny : q_fy;
    end

    // ---- stage C2: overlap test, entry/exit times
    logic               rc2_v;
    t_sb                rc2_sb;
    t_sb                nc2_sb;
    logic signed [31:0] rc2_tn, rc2_tf;
    logic               rc2_gt, rc2_lt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc2_v <= 1'b0;
        end else begin
            rc2_v <= rc1_v;
        end
    end

    always_comb begin
        nc2_sb      = rc1_sb;
        nc2_sb.miss = rc1_sb.miss | (rc1_nx > rc1_fy) | (rc1_ny > rc1_fx);
    end

    always_ff @(posedge i_clk) begin
        rc2_sb <= nc2_sb;
        rc2_tn <= (rc1_nx > rc1_ny) ? rc1_nx : rc1_ny;
        rc2_tf <= (rc1_fx < rc1_fy) ? rc1_fx : rc1_fy;
        rc2_gt <= rc1_nx > rc1_ny;
        rc2_lt <= rc1_nx < rc1_ny;
    end

    // ---- stage C3: range checks, contact products, normal
    logic               rc3_v;
    t_sb                rc3_sb;
    t_sb                nc3_sb;
    logic signed [31:0] rc3_tn;
    logic signed [63:0] rc3_px, rc3_py;
    logic signed [1:0]  rc3_nrx, rc3_nry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc3_v <= 1'b0;
        end else begin
            rc3_v <= rc2_v;
        end
    end

    always_comb begin
        nc3_sb      = rc2_sb;
        nc3_sb.miss = rc2_sb.miss | (rc2_tf < 0) | (rc2_sb.mode & (rc2_tn > ONE_Q));
    end

    always_ff @(posedge i_clk) begin
        rc3_sb  <= nc3_sb;
        rc3_tn  <= rc2_tn;
        rc3_px  <= rc2_tn * rc2_sb.dx;
        rc3_py  <= rc2_tn * rc2_sb.dy;
        rc3_nrx <= rc2_gt ? (rc2_sb.dx[31] ? 2'sd1 : -2'sd1) : 2'sd0;
        rc3_nry <= (!rc2_gt && rc2_lt) ? (rc2_sb.dy[31] ? 2'sd1 : -2'sd1) : 2'sd0;
    end

    // ---- stage C4: contact point with saturation, result register
    logic signed [48:0] n_cx, n_cy;
    logic signed [31:0] n_cxs, n_cys;

    // arithmetic shift gives the floor of the product over 2^16
    assign n_cx = 49'(rc3_sb.ox) + 49'($signed(rc3_px[63:FRAC_W]));
    assign n_cy = 49'(rc3_sb.oy) + 49'($signed(rc3_py[63:FRAC_W]));

    always_comb begin
        if (n_cx > 49'(T_MAX))            n_cxs = T_MAX;
        else if (n_cx < 49'(-T_MAX - 1))  n_cxs = -T_MAX - 32'sd1;
        else                              n_cxs = n_cx[31:0];
        if (n_cy > 49'(T_MAX))            n_cys = T_MAX;
        else if (n_cy < 49'(-T_MAX - 1))  n_cys = -T_MAX - 32'sd1;
        else                              n_cys = n_cy[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= rc3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit        <= ~rc3_sb.miss;
        o_entry_time <= rc3_sb.miss ? '0 : rc3_tn;
        o_contact_x  <= rc3_sb.miss ? '0 : n_cxs;
        o_contact_y  <= rc3_sb.miss ? '0 : n_cys;
        o_normal_x   <= rc3_sb.miss ? '0 : rc3_nrx;
        o_normal_y   <= rc3_sb.miss ? '0 : rc3_nry;
    end

endmodule

// ----- design/sbri_chk.sv -----
// ---------------------------------------------------------------------------
// sbri_chk
// Port-level checks for the slab test block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbri_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic               o_hit,
    input logic signed [31:0] o_entry_time,
    input logic signed [31:0] o_contact_x,
    input logic signed [31:0] o_contact_y,
    input logic signed [1:0]  o_normal_x,
    input logic signed [1:0]  o_normal_y
);
    import sbri_pkg::*;

    // every request gives exactly one strobe after the fixed latency
    `CHK_DELAY(a_lat_hit, i_clk, i_rst_n, start && !busy, PIPE_LAT, o_valid)
    `CHK_DELAY(a_lat_idle, i_clk, i_rst_n, !(start && !busy), PIPE_LAT, !o_valid)
    // a miss reports all zero
    `CHK_IMPL(a_miss_zero, i_clk, i_rst_n, o_valid && !o_hit, (o_entry_time == 0) && (o_contact_x == 0) && (o_contact_y == 0) && (o_normal_x == 0) && (o_normal_y == 0))
    // at most one face normal, never the unused code
    `CHK_IMPL(a_normal, i_clk, i_rst_n, o_valid, (o_normal_x != 2'b10) && (o_normal_y != 2'b10) && ((o_normal_x == 0) || (o_normal_y == 0)))

endmodule

bind swept_box_ray_intersect sbri_chk u_sbri_chk (.*);
